// ===== sv/tpa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants for the triangle primitive assembler.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int INDEX_WIDTH     = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [INDEX_WIDTH-1:0] RESTART_VALUE = '1;

    typedef logic [INDEX_WIDTH-1:0] index_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_STRIP_MODE   = 2'd0,
        CFG_VERTEX_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SLOT_FIRST  = 2'd0,
        SLOT_SECOND = 2'd1,
        SLOT_THIRD  = 2'd2
    } list_slot_t;

    typedef struct packed {
        index_t     older_index;
        index_t     newer_index;
        logic       strip_parity;
        list_slot_t list_slot;
    } asm_state_t;

    typedef struct packed {
        index_t vert_a;
        index_t vert_b;
        index_t vert_c;
    } corners_t;

    localparam asm_state_t ASM_CLEAR = '{
        older_index:  RESTART_VALUE,
        newer_index:  RESTART_VALUE,
        strip_parity: 1'b0,
        list_slot:    SLOT_FIRST
    };

endpackage

// ===== sv/tpa_if.sv =====
// ----------------------------------------------------------------------------
// tpa_if
// Valid/ready channels of the triangle primitive assembler.
// ----------------------------------------------------------------------------
interface tpa_index_if;
    import tpa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] index_value;
    logic                   draw_start;

    modport source (output valid, output index_value, output draw_start, input ready);
    modport sink   (input valid, input index_value, input draw_start, output ready);
endinterface

interface tpa_tri_if;
    import tpa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] vert_a;
    logic [FIELD_WIDTH-1:0] vert_b;
    logic [FIELD_WIDTH-1:0] vert_c;

    modport source (output valid, output vert_a, output vert_b, output vert_c, input ready);
    modport sink   (input valid, input vert_a, input vert_b, input vert_c, output ready);
endinterface

interface tpa_cfg_if;
    import tpa_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/tpa_step.sv =====
// ----------------------------------------------------------------------------
// tpa_step
// Next assembly state and culled triangle for one index beat.
// ----------------------------------------------------------------------------
module tpa_step
    import tpa_pkg::*;
(
    input  asm_state_t             state,
    input  index_t                 index_value,
    input  logic                   draw_start,
    input  logic                   strip_mode,
    input  logic [FIELD_WIDTH-1:0] vertex_count,
    output asm_state_t             state_next,
    output logic                   emit,
    output corners_t               corners
);

    asm_state_t base;
    logic       complete;
    logic       distinct;
    logic       in_range;

    always_comb
    begin
        // draw start clears assembly before the index is taken in
        base       = draw_start ? ASM_CLEAR : state;
        state_next = base;
        complete   = 1'b0;
        corners    = '{vert_a: base.older_index, vert_b: base.newer_index,
                       vert_c: index_value};

        if (strip_mode)
        begin
            if (index_value == RESTART_VALUE)
            begin
                state_next.older_index  = RESTART_VALUE;
                state_next.newer_index  = RESTART_VALUE;
                state_next.strip_parity = 1'b0;
            end
            else
            begin
                complete = (base.older_index != RESTART_VALUE) &&
                           (base.newer_index != RESTART_VALUE);
                // odd steps swap the first two corners to keep winding
                if (base.strip_parity)
                begin
                    corners.vert_a = base.newer_index;
                    corners.vert_b = base.older_index;
                end
                state_next.older_index  = base.newer_index;
                state_next.newer_index  = index_value;
                state_next.strip_parity = ~base.strip_parity;
            end
        end
        else
        begin
            case (base.list_slot)
                SLOT_SECOND:
                begin
                    state_next.newer_index = index_value;
                    state_next.list_slot   = SLOT_THIRD;
                end
                SLOT_THIRD:
                begin
                    complete = (base.older_index != RESTART_VALUE) &&
                               (base.newer_index != RESTART_VALUE) &&
                               (index_value != RESTART_VALUE);
                    state_next.list_slot = SLOT_FIRST;
                end
                default:
                begin
                    state_next.older_index = index_value;
                    state_next.list_slot   = SLOT_SECOND;
                end
            endcase
        end
    end

    assign distinct = (corners.vert_a != corners.vert_b) &&
                      (corners.vert_b != corners.vert_c) &&
                      (corners.vert_a != corners.vert_c);
    assign in_range = (FIELD_WIDTH'(corners.vert_a) < vertex_count) &&
                      (FIELD_WIDTH'(corners.vert_b) < vertex_count) &&
                      (FIELD_WIDTH'(corners.vert_c) < vertex_count);
    assign emit     = complete && distinct && in_range;

endmodule

// ===== sv/triangle_primitive_assembler_core.sv =====
// Output: a triangle's last index beat loads corners_reg, or skid_reg if stalled.
// Throughput: one index beat per cycle; a triangle stalled by the downstream parks
// in a skid register, so the index channel waits only while two triangles are held.
// Reset: rst_n clears the assembly state, strip_mode and vertex_count at once.
// ----------------------------------------------------------------------------
// triangle_primitive_assembler_core
// Builds strip or list triangles from an index stream and culls degenerate or
// out-of-range triangles.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler_core
    import tpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tpa_index_if.sink  indices,
    tpa_tri_if.source  triangles,
    tpa_cfg_if.sink    cfg
);

    asm_state_t             state_reg;
    asm_state_t             state_next;
    logic                   strip_mode_reg;
    logic [FIELD_WIDTH-1:0] vertex_count_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    corners_t               corners_reg;
    corners_t               corners_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    corners_t               skid_reg;
    logic                   out_take;
    logic                   push;
    logic                   emit;
    logic                   in_fire;
    logic                   cfg_fire;

    assign indices.ready = !skid_valid_reg;
    assign in_fire       = indices.valid && indices.ready;
    assign cfg.ready     = 1'b1;
    assign cfg_fire      = cfg.valid && cfg.ready;
    assign out_take      = out_valid_reg && triangles.ready;
    assign push          = in_fire && emit;

    tpa_step u_step (
        .state        (state_reg),
        .index_value  (indices.index_value[INDEX_WIDTH-1:0]),
        .draw_start   (indices.draw_start),
        .strip_mode   (strip_mode_reg),
        .vertex_count (vertex_count_reg),
        .state_next   (state_next),
        .emit         (emit),
        .corners      (corners_next)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // advance the parked triangle into the output register
            if (out_take)
                skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !triangles.ready)
                skid_valid_next = 1'b1;
            else
                out_valid_next = 1'b1;
        end
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ASM_CLEAR;
            strip_mode_reg   <= 1'b0;
            vertex_count_reg <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (in_fire)
                state_reg <= state_next;
            if (cfg_fire)
            begin
                case (cfg.index)
                    CFG_STRIP_MODE:   strip_mode_reg   <= cfg.data[0];
                    CFG_VERTEX_COUNT: vertex_count_reg <= cfg.data[FIELD_WIDTH-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // hold the payload until the downstream takes the beat
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                corners_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !triangles.ready)
                skid_reg <= corners_next;
            else
                corners_reg <= corners_next;
        end
    end

    assign triangles.valid  = out_valid_reg;
    assign triangles.vert_a = FIELD_WIDTH'(corners_reg.vert_a);
    assign triangles.vert_b = FIELD_WIDTH'(corners_reg.vert_b);
    assign triangles.vert_c = FIELD_WIDTH'(corners_reg.vert_c);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !triangles.ready |=> out_valid_reg)
        else $error("pending triangle dropped under backpressure");

    a_emit_culled: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && emit |-> (corners_next.vert_a != corners_next.vert_b) &&
            (FIELD_WIDTH'(corners_next.vert_c) < vertex_count_reg))
        else $error("degenerate or out-of-range triangle emitted");

    a_strip_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && strip_mode_reg &&
            (indices.index_value[INDEX_WIDTH-1:0] == RESTART_VALUE)
        |=> (state_reg.older_index == RESTART_VALUE) &&
            (state_reg.newer_index == RESTART_VALUE) && !state_reg.strip_parity)
        else $error("strip restart did not clear corners");

    a_list_draw_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !strip_mode_reg && indices.draw_start
        |=> state_reg.list_slot == SLOT_SECOND)
        else $error("draw start did not begin a new list triple");

    a_no_emit_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && indices.draw_start && !out_valid_reg |=> !out_valid_reg)
        else $error("triangle emitted from the first index of a draw");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a triangle ahead of the output");

endmodule
